@@ src/eht_pkg.sv @@
`timescale 1ns / 1ps

package eht_pkg;

    localparam int unsigned C_MAX_GLOBAL_DEPTH = 6;
    localparam int unsigned C_NUM_BUCKETS      = 64;
    localparam int unsigned C_MAX_SLOTS        = 8;
    localparam int unsigned C_RECORD_WIDTH     = 32;
    localparam int unsigned C_CAP_RESET        = 4;

    localparam logic [1:0] REQ_INSERT = 2'd0;
    localparam logic [1:0] REQ_SEARCH = 2'd1;
    localparam logic [1:0] REQ_REMOVE = 2'd2;

    typedef enum logic [2:0] {
        ST_INSERTED  = 3'd0,
        ST_FOUND     = 3'd1,
        ST_REMOVED   = 3'd2,
        ST_DUPLICATE = 3'd3,
        ST_NOT_FOUND = 3'd4,
        ST_FULL      = 3'd5
    } t_status;

    typedef enum logic [4:0] {
        S_IDLE,
        S_DIR,
        S_BKT,
        S_META,
        S_SCAN_RD,
        S_SCAN_CMP,
        S_RM_RD,
        S_RM_WR,
        S_INS,
        S_DBL_RD,
        S_DBL_WR,
        S_SPLIT,
        S_MV_RD,
        S_MV_WR,
        S_META_OLD,
        S_META_NEW,
        S_RP_RD,
        S_RP_WR,
        S_DONE
    } t_state;

endpackage

@@ src/eht_if.sv @@
`timescale 1ns / 1ps

interface eht_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  req_type;
    logic [63:0] key_hash;
    logic [31:0] record_in;

    modport source (output valid, output req_type, output key_hash, output record_in,
                    input ready);
    modport sink (input valid, input req_type, input key_hash, input record_in,
                  output ready);
endinterface

interface eht_rsp_if;
    logic        valid;
    logic        ready;
    logic [2:0]  status;
    logic [31:0] record_out;

    modport source (output valid, output status, output record_out, input ready);
    modport sink (input valid, input status, input record_out, output ready);
endinterface

@@ src/extendible_hash_table.sv @@
`timescale 1ns / 1ps

// Extendible hash table: one result beat per request beat (insert, search, remove, or any
// other type, which gets not-found), keyed by the 64-bit key hash. A new request is taken
// only when the previous one has finished its walk; its result may still wait in the output
// register. Every table access goes through single-read-port memories with registered read
// data. An insert into a full bucket adds, per split, a move pass over the bucket's slots,
// a repointing pass over the directory entries in use, a mirroring pass over the entries of
// the old directory when it doubles, and a new lookup. No clearing pass follows reset.
module extendible_hash_table #(
    parameter int unsigned MAX_GLOBAL_DEPTH = eht_pkg::C_MAX_GLOBAL_DEPTH,
    parameter int unsigned NUM_BUCKETS      = eht_pkg::C_NUM_BUCKETS,
    parameter int unsigned MAX_SLOTS        = eht_pkg::C_MAX_SLOTS,
    parameter int unsigned RECORD_WIDTH     = eht_pkg::C_RECORD_WIDTH
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    eht_req_if.sink    i_req,
    eht_rsp_if.source  o_rsp,
    input  logic       i_cfg_we,
    input  logic [3:0] i_cfg_wdata
);
    import eht_pkg::*;

    localparam int unsigned DW  = MAX_GLOBAL_DEPTH;
    localparam int unsigned BW  = $clog2(NUM_BUCKETS);
    localparam int unsigned LDW = $clog2(MAX_GLOBAL_DEPTH + 1);
    localparam int unsigned FW  = $clog2(MAX_SLOTS + 1);
    localparam int unsigned SAW = $clog2(NUM_BUCKETS * MAX_SLOTS);
    localparam int unsigned NFW = $clog2(NUM_BUCKETS + 1);
    localparam int unsigned RSW = (RECORD_WIDTH < 32) ? RECORD_WIDTH : 32;
    localparam int unsigned MW  = LDW + FW;
    localparam int unsigned SLW = 64 + RSW;

    // global state
    t_state           r_state, n_state;
    logic [3:0]       r_spb;
    logic [LDW-1:0]   r_gd, n_gd;
    logic [NFW-1:0]   r_nfb, n_nfb;
    logic             r_b0_init, n_b0_init;
    // request context
    logic [1:0]       r_req, n_req;
    logic [63:0]      r_key, n_key;
    logic [RSW-1:0]   r_rec, n_rec;
    logic [RSW-1:0]   r_frec, n_frec;
    t_status          r_status, n_status;
    logic             r_retry, n_retry;
    logic [BW-1:0]    r_b, n_b;
    logic [BW-1:0]    r_fresh, n_fresh;
    logic [LDW-1:0]   r_ld, n_ld;
    logic [FW-1:0]    r_fill, n_fill;
    logic [FW-1:0]    r_i, n_i;
    logic [FW-1:0]    r_s, n_s;
    logic [FW-1:0]    r_o, n_o;
    logic [FW-1:0]    r_f, n_f;
    logic [DW:0]      r_j, n_j;
    // output register
    logic             r_out_valid, n_out_valid;
    t_status          r_out_status, n_out_status;
    logic [RSW-1:0]   r_out_rec, n_out_rec;

    // memory ports
    logic             w_dir_we;
    logic [DW-1:0]    w_dir_waddr, w_dir_raddr;
    logic [BW-1:0]    w_dir_wdata, w_dir_ram_q, w_dir_q;
    logic             r_dir_ra0;
    logic             w_meta_we;
    logic [BW-1:0]    w_meta_waddr, w_meta_raddr;
    logic [MW-1:0]    w_meta_wdata, w_meta_ram_q, w_meta_q;
    logic             r_meta_ra0;
    logic             w_slot_we;
    logic [SAW-1:0]   w_slot_waddr, w_slot_raddr;
    logic [SLW-1:0]   w_slot_wdata, w_slot_q;

    logic [DW:0]      w_size;
    logic [DW-1:0]    w_dir_idx;
    logic [FW-1:0]    w_cap;
    logic [63:0]      w_slot_key;
    logic [RSW-1:0]   w_slot_rec;
    logic             w_accept;
    logic             w_out_load;

    assign w_size      = (DW + 1)'(1) << r_gd;
    assign w_dir_idx   = r_key[DW-1:0] & DW'(w_size - (DW + 1)'(1));
    assign w_slot_key  = w_slot_q[SLW-1:RSW];
    assign w_slot_rec  = w_slot_q[RSW-1:0];
    assign w_dir_q     = r_dir_ra0 ? '0 : w_dir_ram_q;
    assign w_meta_q    = (r_meta_ra0 && !r_b0_init) ? '0 : w_meta_ram_q;
    assign w_accept    = i_req.valid && i_req.ready;
    assign w_out_load  = (r_state == S_DONE) && (!r_out_valid || o_rsp.ready);

    always_comb begin
        if (r_spb == 4'd0) begin
            w_cap = FW'(1);
        end else if ({4'd0, r_spb} > 8'(MAX_SLOTS)) begin
            w_cap = FW'(MAX_SLOTS);
        end else begin
            w_cap = FW'(r_spb);
        end
    end

    function automatic logic [SAW-1:0] slot_addr(input logic [BW-1:0] b,
                                                 input logic [FW-1:0] idx);
        return SAW'(SAW'(b) * SAW'(MAX_SLOTS)) + SAW'(idx);
    endfunction

    eht_ram #(.WIDTH(BW), .DEPTH(1 << MAX_GLOBAL_DEPTH)) u_dir (
        .i_clk(i_clk), .i_we(w_dir_we), .i_waddr(w_dir_waddr), .i_wdata(w_dir_wdata),
        .i_raddr(w_dir_raddr), .o_rdata(w_dir_ram_q)
    );

    eht_ram #(.WIDTH(MW), .DEPTH(NUM_BUCKETS)) u_meta (
        .i_clk(i_clk), .i_we(w_meta_we), .i_waddr(w_meta_waddr), .i_wdata(w_meta_wdata),
        .i_raddr(w_meta_raddr), .o_rdata(w_meta_ram_q)
    );

    eht_ram #(.WIDTH(SLW), .DEPTH(NUM_BUCKETS * MAX_SLOTS)) u_slot (
        .i_clk(i_clk), .i_we(w_slot_we), .i_waddr(w_slot_waddr), .i_wdata(w_slot_wdata),
        .i_raddr(w_slot_raddr), .o_rdata(w_slot_q)
    );

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    if (i_req.req_type == REQ_INSERT || i_req.req_type == REQ_SEARCH ||
                        i_req.req_type == REQ_REMOVE) begin
                        n_state = S_DIR;
                    end else begin
                        n_state = S_DONE;
                    end
                end
            end
            S_DIR:      n_state = S_BKT;
            S_BKT:      n_state = S_META;
            S_META:     n_state = r_retry ? S_INS : S_SCAN_RD;
            S_SCAN_RD: begin
                if (r_i == r_fill) begin
                    n_state = (r_req == REQ_INSERT) ? S_INS : S_DONE;
                end else begin
                    n_state = S_SCAN_CMP;
                end
            end
            S_SCAN_CMP: begin
                if (w_slot_key == r_key) begin
                    n_state = (r_req == REQ_REMOVE) ? S_RM_RD : S_DONE;
                end else begin
                    n_state = S_SCAN_RD;
                end
            end
            S_RM_RD:    n_state = S_RM_WR;
            S_RM_WR:    n_state = S_DONE;
            S_INS: begin
                if (r_fill < w_cap) begin
                    n_state = S_DONE;
                end else if (r_ld >= r_gd && r_gd >= LDW'(MAX_GLOBAL_DEPTH)) begin
                    n_state = S_DONE;
                end else if (r_nfb >= NFW'(NUM_BUCKETS)) begin
                    n_state = S_DONE;
                end else if (r_ld >= r_gd) begin
                    n_state = S_DBL_RD;
                end else begin
                    n_state = S_SPLIT;
                end
            end
            S_DBL_RD:   n_state = (r_j == w_size) ? S_SPLIT : S_DBL_WR;
            S_DBL_WR:   n_state = S_DBL_RD;
            S_SPLIT:    n_state = S_MV_RD;
            S_MV_RD:    n_state = (r_i == r_fill) ? S_META_OLD : S_MV_WR;
            S_MV_WR:    n_state = S_MV_RD;
            S_META_OLD: n_state = S_META_NEW;
            S_META_NEW: n_state = S_RP_RD;
            S_RP_RD:    n_state = (r_j == w_size) ? S_DIR : S_RP_WR;
            S_RP_WR:    n_state = S_RP_RD;
            S_DONE:     n_state = w_out_load ? S_IDLE : S_DONE;
            default:    n_state = S_IDLE;
        endcase
    end

    // datapath and memory controls
    always_comb begin
        n_gd         = r_gd;
        n_nfb        = r_nfb;
        n_b0_init    = r_b0_init;
        n_req        = r_req;
        n_key        = r_key;
        n_rec        = r_rec;
        n_frec       = r_frec;
        n_status     = r_status;
        n_retry      = r_retry;
        n_b          = r_b;
        n_fresh      = r_fresh;
        n_ld         = r_ld;
        n_fill       = r_fill;
        n_i          = r_i;
        n_s          = r_s;
        n_o          = r_o;
        n_f          = r_f;
        n_j          = r_j;
        n_out_valid  = r_out_valid;
        n_out_status = r_out_status;
        n_out_rec    = r_out_rec;
        w_dir_we     = 1'b0;
        w_dir_waddr  = r_j[DW-1:0];
        w_dir_wdata  = r_fresh;
        w_dir_raddr  = r_j[DW-1:0];
        w_meta_we    = 1'b0;
        w_meta_waddr = r_b;
        w_meta_wdata = {r_ld, r_fill};
        w_meta_raddr = w_dir_q;
        w_slot_we    = 1'b0;
        w_slot_waddr = slot_addr(r_b, r_s);
        w_slot_wdata = {r_key, r_rec};
        w_slot_raddr = slot_addr(r_b, r_i);

        if (r_out_valid && o_rsp.ready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_req    = i_req.req_type;
                    n_key    = i_req.key_hash;
                    n_rec    = i_req.record_in[RSW-1:0];
                    n_frec   = '0;
                    n_retry  = 1'b0;
                    n_status = ST_NOT_FOUND;
                end
            end
            S_DIR: begin
                w_dir_raddr = w_dir_idx;
            end
            S_BKT: begin
                n_b = w_dir_q;
            end
            S_META: begin
                {n_ld, n_fill} = w_meta_q;
                n_i            = '0;
            end
            S_SCAN_RD: begin
                if (r_i == r_fill) begin
                    n_status = ST_NOT_FOUND;
                end
            end
            S_SCAN_CMP: begin
                if (w_slot_key == r_key) begin
                    n_s    = r_i;
                    n_frec = w_slot_rec;
                    unique case (r_req)
                        REQ_SEARCH: n_status = ST_FOUND;
                        REQ_REMOVE: n_status = ST_REMOVED;
                        default: begin
                            n_status = ST_DUPLICATE;
                            n_frec   = '0;
                        end
                    endcase
                end else begin
                    n_i = r_i + FW'(1);
                end
            end
            S_RM_RD: begin
                w_slot_raddr = slot_addr(r_b, r_fill - FW'(1));
            end
            S_RM_WR: begin
                // move the last slot into the hole
                w_slot_we    = 1'b1;
                w_slot_waddr = slot_addr(r_b, r_s);
                w_slot_wdata = w_slot_q;
                w_meta_we    = 1'b1;
                w_meta_wdata = {r_ld, r_fill - FW'(1)};
                if (r_b == '0) begin
                    n_b0_init = 1'b1;
                end
            end
            S_INS: begin
                n_j = '0;
                if (r_fill < w_cap) begin
                    w_slot_we    = 1'b1;
                    w_slot_waddr = slot_addr(r_b, r_fill);
                    w_meta_we    = 1'b1;
                    w_meta_wdata = {r_ld, r_fill + FW'(1)};
                    n_status     = ST_INSERTED;
                    if (r_b == '0) begin
                        n_b0_init = 1'b1;
                    end
                end else if (r_ld >= r_gd && r_gd >= LDW'(MAX_GLOBAL_DEPTH)) begin
                    n_status = ST_FULL;
                end else if (r_nfb >= NFW'(NUM_BUCKETS)) begin
                    n_status = ST_FULL;
                end
            end
            S_DBL_RD: begin
                if (r_j == w_size) begin
                    n_gd = r_gd + LDW'(1);
                end
            end
            S_DBL_WR: begin
                // mirror the lower half into the upper half
                w_dir_we    = 1'b1;
                w_dir_waddr = DW'(r_j + w_size);
                w_dir_wdata = w_dir_q;
                n_j         = r_j + (DW + 1)'(1);
            end
            S_SPLIT: begin
                n_fresh = r_nfb[BW-1:0];
                n_nfb   = r_nfb + NFW'(1);
                n_i     = '0;
                n_o     = '0;
                n_f     = '0;
            end
            S_MV_RD: begin
                w_slot_raddr = slot_addr(r_b, r_i);
            end
            S_MV_WR: begin
                // compact in place: the old bucket's write index never passes the read index
                w_slot_we    = 1'b1;
                w_slot_wdata = w_slot_q;
                if (w_slot_key[r_ld]) begin
                    w_slot_waddr = slot_addr(r_fresh, r_f);
                    n_f          = r_f + FW'(1);
                end else begin
                    w_slot_waddr = slot_addr(r_b, r_o);
                    n_o          = r_o + FW'(1);
                end
                n_i = r_i + FW'(1);
            end
            S_META_OLD: begin
                w_meta_we    = 1'b1;
                w_meta_waddr = r_b;
                w_meta_wdata = {r_ld + LDW'(1), r_o};
                if (r_b == '0) begin
                    n_b0_init = 1'b1;
                end
            end
            S_META_NEW: begin
                w_meta_we    = 1'b1;
                w_meta_waddr = r_fresh;
                w_meta_wdata = {r_ld + LDW'(1), r_f};
                n_j          = '0;
            end
            S_RP_RD: begin
                if (r_j == w_size) begin
                    n_retry = 1'b1;
                end
            end
            S_RP_WR: begin
                if (w_dir_q == r_b && r_j[r_ld]) begin
                    w_dir_we    = 1'b1;
                    w_dir_waddr = r_j[DW-1:0];
                end
                n_j = r_j + (DW + 1)'(1);
            end
            S_DONE: begin
                if (w_out_load) begin
                    n_out_valid  = 1'b1;
                    n_out_status = r_status;
                    n_out_rec    = r_frec;
                end
            end
            default: begin
                n_j = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_spb       <= 4'(C_CAP_RESET);
            r_gd        <= '0;
            r_nfb       <= NFW'(1);
            r_b0_init   <= 1'b0;
            r_retry     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_gd        <= n_gd;
            r_nfb       <= n_nfb;
            r_b0_init   <= n_b0_init;
            r_retry     <= n_retry;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                r_spb <= i_cfg_wdata;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_req        <= n_req;
        r_key        <= n_key;
        r_rec        <= n_rec;
        r_frec       <= n_frec;
        r_status     <= n_status;
        r_b          <= n_b;
        r_fresh      <= n_fresh;
        r_ld         <= n_ld;
        r_fill       <= n_fill;
        r_i          <= n_i;
        r_s          <= n_s;
        r_o          <= n_o;
        r_f          <= n_f;
        r_j          <= n_j;
        r_out_status <= n_out_status;
        r_out_rec    <= n_out_rec;
        // directory entry 0 always names bucket 0
        r_dir_ra0    <= (w_dir_raddr == '0);
        r_meta_ra0   <= (w_meta_raddr == '0);
    end

    assign i_req.ready      = (r_state == S_IDLE);
    assign o_rsp.valid      = r_out_valid;
    assign o_rsp.status     = r_out_status;
    assign o_rsp.record_out = 32'(r_out_rec);

    a_nfb_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_nfb <= NFW'(NUM_BUCKETS))
        else $error("bucket allocator overran the pool");

    a_gd_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_gd <= LDW'(MAX_GLOBAL_DEPTH))
        else $error("global depth beyond limit");

    a_ld_le_gd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_INS) |-> (r_ld <= r_gd))
        else $error("local depth exceeds global depth");

    a_inplace: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_MV_WR) |-> (r_o <= r_i))
        else $error("split compaction overtook its read index");

    a_split_grow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SPLIT) |=> (r_nfb == $past(r_nfb) + NFW'(1)))
        else $error("split did not allocate a fresh bucket");
endmodule

@@ src/eht_ram.sv @@
`timescale 1ns / 1ps

module eht_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_q;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_q <= r_mem[i_raddr];
    end

    assign o_rdata = r_q;
endmodule

@@ dv/tb_extendible_hash_table.sv @@
`timescale 1ns / 1ps

module tb_extendible_hash_table;
    import eht_pkg::*;

    localparam int unsigned DIR_ENTRIES = 1 << C_MAX_GLOBAL_DEPTH;
    localparam int unsigned WATCHDOG_LIMIT = 20000;

    typedef struct packed {
        logic [2:0]  status;
        logic [31:0] record;
    } t_answer;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_cfg_we = 1'b0;
    logic [3:0] i_cfg_wdata = '0;

    eht_req_if req_ch ();
    eht_rsp_if rsp_ch ();

    extendible_hash_table u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req       (req_ch.sink),
        .o_rsp       (rsp_ch.source),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata)
    );

    always #6 i_clk = ~i_clk;

    // shadow table
    logic [3:0]  sh_cap_reg;
    int unsigned sh_gdepth;
    int unsigned sh_dir [DIR_ENTRIES];
    int unsigned sh_ldepth [C_NUM_BUCKETS];
    int unsigned sh_fill [C_NUM_BUCKETS];
    logic [63:0] sh_key [C_NUM_BUCKETS][C_MAX_SLOTS];
    logic [31:0] sh_rec [C_NUM_BUCKETS][C_MAX_SLOTS];
    int unsigned sh_next_free;

    t_answer     expected_answers[$];
    logic [63:0] stored_keys[$];
    int          error_count = 0;
    bit          quiet_mode = 1'b0;
    int unsigned idle_cycles = 0;
    int unsigned rsp_stall = 0;

    function automatic void table_reset();
        sh_cap_reg = 4'(C_CAP_RESET);
        sh_gdepth = 0;
        foreach (sh_dir[i]) sh_dir[i] = 0;
        foreach (sh_ldepth[i]) begin
            sh_ldepth[i] = 0;
            sh_fill[i] = 0;
        end
        sh_next_free = 1;
        stored_keys.delete();
    endfunction

    function automatic int unsigned bucket_cap();
        if (sh_cap_reg < 1) return 1;
        if (sh_cap_reg > C_MAX_SLOTS) return C_MAX_SLOTS;
        return sh_cap_reg;
    endfunction

    function automatic int unsigned home_bucket(logic [63:0] key);
        logic [63:0] mask;
        mask = (64'd1 << sh_gdepth) - 64'd1;
        return sh_dir[int'(key & mask) % DIR_ENTRIES];
    endfunction

    function automatic int slot_of(int unsigned b, logic [63:0] key);
        for (int i = 0; i < sh_fill[b] && i < C_MAX_SLOTS; i++)
            if (sh_key[b][i] == key) return i;
        return -1;
    endfunction

    function automatic void push_slot(int unsigned b, logic [63:0] key, logic [31:0] rec);
        if (sh_fill[b] >= C_MAX_SLOTS) return;
        sh_key[b][sh_fill[b]] = key;
        sh_rec[b][sh_fill[b]] = rec;
        sh_fill[b]++;
    endfunction

    function automatic void divide_bucket(int unsigned old_b);
        logic [63:0] keys [C_MAX_SLOTS];
        logic [31:0] recs [C_MAX_SLOTS];
        int unsigned fresh;
        int unsigned dep;
        int unsigned n;
        fresh = sh_next_free;
        dep = sh_ldepth[old_b] + 1;
        n = sh_fill[old_b];
        sh_next_free++;
        keys = sh_key[old_b];
        recs = sh_rec[old_b];
        sh_ldepth[old_b] = dep;
        sh_ldepth[fresh] = dep;
        sh_fill[old_b] = 0;
        sh_fill[fresh] = 0;
        for (int i = 0; i < n; i++)
            push_slot(keys[i][dep-1] ? fresh : old_b, keys[i], recs[i]);
        for (int i = 0; i < (1 << sh_gdepth); i++)
            if (sh_dir[i] == old_b && ((i >> (dep - 1)) & 1)) sh_dir[i] = fresh;
    endfunction

    function automatic t_status table_insert(logic [63:0] key, logic [31:0] rec);
        int unsigned b;
        if (slot_of(home_bucket(key), key) >= 0) return ST_DUPLICATE;
        forever begin
            b = home_bucket(key);
            if (sh_fill[b] < bucket_cap()) begin
                push_slot(b, key, rec);
                stored_keys.push_back(key);
                return ST_INSERTED;
            end
            if (sh_ldepth[b] >= sh_gdepth && sh_gdepth >= C_MAX_GLOBAL_DEPTH) return ST_FULL;
            if (sh_next_free >= C_NUM_BUCKETS) return ST_FULL;
            if (sh_ldepth[b] >= sh_gdepth) begin
                for (int i = 0; i < (1 << sh_gdepth); i++)
                    sh_dir[i + (1 << sh_gdepth)] = sh_dir[i];
                sh_gdepth++;
            end
            divide_bucket(b);
        end
    endfunction

    function automatic t_answer table_apply(logic [1:0] kind, logic [63:0] key,
                                            logic [31:0] rec);
        t_answer ans;
        int unsigned b;
        int s;
        int unsigned last;
        ans.status = ST_NOT_FOUND;
        ans.record = '0;
        if (kind == REQ_INSERT) begin
            ans.status = table_insert(key, rec);
        end else if (kind == REQ_SEARCH || kind == REQ_REMOVE) begin
            b = home_bucket(key);
            s = slot_of(b, key);
            if (s >= 0) begin
                ans.record = sh_rec[b][s];
                if (kind == REQ_SEARCH) begin
                    ans.status = ST_FOUND;
                end else begin
                    last = sh_fill[b] - 1;
                    sh_key[b][s] = sh_key[b][last];
                    sh_rec[b][s] = sh_rec[b][last];
                    sh_fill[b]--;
                    ans.status = ST_REMOVED;
                end
            end
        end
        return ans;
    endfunction

    // valid stays high from one beat to the next unless an idle burst or a drain drops it
    task automatic send_request(logic [1:0] kind, logic [63:0] key, logic [31:0] rec);
        if (!quiet_mode && $urandom_range(0, 3) == 0) begin
            req_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
        req_ch.valid <= 1'b1;
        req_ch.req_type <= kind;
        req_ch.key_hash <= key;
        req_ch.record_in <= rec;
        expected_answers.push_back(table_apply(kind, key, rec));
        do @(posedge i_clk); while (!req_ch.ready);
    endtask

    task automatic drain();
        req_ch.valid <= 1'b0;
        while (expected_answers.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    task automatic write_capacity(logic [3:0] v);
        drain();
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= v;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        sh_cap_reg = v;
    endtask

    function automatic logic [63:0] rand_key();
        return {$urandom(), $urandom()};
    endfunction

    function automatic logic [63:0] known_key();
        if (stored_keys.size() == 0) return rand_key();
        return stored_keys[$urandom_range(0, stored_keys.size() - 1)];
    endfunction

    // response side: random stall bursts, compare each beat
    always @(posedge i_clk) begin
        t_answer exp_ans;
        if (!i_rst_n) begin
            rsp_ch.ready <= 1'b0;
            rsp_stall <= 0;
        end else begin
            if (rsp_ch.valid && rsp_ch.ready) begin
                if (expected_answers.size() == 0) begin
                    $error("unexpected result beat status=%0d", rsp_ch.status);
                    error_count++;
                end else begin
                    exp_ans = expected_answers.pop_front();
                    if (rsp_ch.status !== exp_ans.status) begin
                        $error("status expected %0d actual %0d", exp_ans.status,
                               rsp_ch.status);
                        error_count++;
                    end
                    if (rsp_ch.record_out !== exp_ans.record) begin
                        $error("record_out expected %h actual %h", exp_ans.record,
                               rsp_ch.record_out);
                        error_count++;
                    end
                end
            end
            if (rsp_stall > 1) begin
                rsp_ch.ready <= 1'b0;
                rsp_stall <= rsp_stall - 1;
            end else if (rsp_stall == 1) begin
                rsp_ch.ready <= 1'b1;
                rsp_stall <= 0;
            end else if (!quiet_mode && $urandom_range(0, 3) == 0) begin
                rsp_ch.ready <= 1'b0;
                rsp_stall <= $urandom_range(1, 4);
            end else begin
                rsp_ch.ready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    task automatic test_directed();
        send_request(REQ_SEARCH, 64'd0, 32'd0);
        send_request(REQ_REMOVE, 64'hFFFF_FFFF_FFFF_FFFF, 32'd0);
        send_request(REQ_INSERT, 64'd0, 32'hFFFF_FFFF);
        send_request(REQ_INSERT, 64'd0, 32'h1234_5678);
        send_request(REQ_INSERT, 64'hFFFF_FFFF_FFFF_FFFF, 32'd0);
        send_request(REQ_SEARCH, 64'd0, 32'd0);
        send_request(2'd3, 64'd0, 32'hA5A5_A5A5);
        // fill bucket 0 past capacity to force doublings and splits
        for (int i = 1; i <= 8; i++)
            send_request(REQ_INSERT, 64'(i) << 1, 32'(i * 17));
        send_request(REQ_REMOVE, 64'd0, 32'd0);
        send_request(REQ_REMOVE, 64'd0, 32'd0);
        send_request(REQ_SEARCH, 64'd16, 32'd0);
        send_request(REQ_SEARCH, 64'hFFFF_FFFF_FFFF_FFFF, 32'd0);
    endtask

    // keys sharing low bits exhaust depth limit
    task automatic test_table_full();
        write_capacity(4'd1);
        for (int i = 0; i < 12; i++)
            send_request(REQ_INSERT, {rand_key()} << 7 | 64'h55, $urandom());
    endtask

    task automatic test_capacity_lowered();
        write_capacity(4'd8);
        for (int i = 0; i < 10; i++) send_request(REQ_INSERT, rand_key(), $urandom());
        write_capacity(4'd2);
        for (int i = 0; i < 6; i++) send_request(REQ_INSERT, rand_key(), $urandom());
    endtask

    task automatic test_random_phase(logic [3:0] cap, int n);
        logic [1:0] kind;
        logic [63:0] key;
        write_capacity(cap);
        for (int i = 0; i < n; i++) begin
            kind = 2'($urandom_range(0, 9) < 5 ? 0 : $urandom_range(1, 3));
            key = ($urandom_range(0, 1) != 0) ? known_key() : rand_key();
            send_request(kind, key, $urandom());
        end
    endtask

    initial begin
        req_ch.valid = 1'b0;
        req_ch.req_type = '0;
        req_ch.key_hash = '0;
        req_ch.record_in = '0;
        table_reset();
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_table_full();
        test_capacity_lowered();
        // each phase only changes the capacity; table state persists across phases
        test_random_phase(4'd0, 150);
        test_random_phase(4'd15, 200);
        test_random_phase(4'd3, 200);
        test_random_phase(4'd8, 150);
        quiet_mode = 1'b1;
        test_random_phase(4'd4, 200);
        drain();
        if (error_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
